// File: rtl/cpf_pkg.sv
package cpf_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'hAA;
  localparam int          QUEUE_DEPTH_DEF   = 4;

  // Configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // Input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_ERROR
  } kind_t;

  // Classified command handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        close;
    logic [7:0]  fun_code;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
  } cmd_t;

  // Fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crc16_packet_framer_top.sv
// CRC-16 packet framer.
// Input channel (in_valid / in_stall): op 0 opens a frame with fun_code and
// frame_length and yields five header results (two sync bytes, function code,
// length high, length low); op 1 passes data_byte through. After the last
// payload byte, or right after the header when frame_length is zero, the
// CRC-16 (reflected 0xA001, init 0xFFFF) follows high byte first, with
// frame_end on the low byte. Data with no open frame yields one result with
// error set and tx_byte zero. last marks the final result of each item.
// Output channel (out_valid / out_stall): one result per cycle while the
// receiver does not stall, from an output register fed by a command queue
// of QUEUE_DEPTH entries; the queue separates the accepting front from the
// emitting back, so the front keeps accepting items while the back emits
// earlier results. When the receiver stalls, the output holds and the queue
// fills; in_stall rises once the queue is full. Reset clears the frame
// state, the queue and out_valid and restores the sync bytes to 0x55 and
// 0xAA. Sync bytes are written over cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, and the block does not enforce this.
module crc16_packet_framer_top
  import cpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  fun_code,
  input  logic [15:0] frame_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        frame_end,
  output logic        error,
  output logic        last
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic       push;
  cmd_t       push_cmd;
  logic       full;
  logic       pop;
  logic       head_valid;
  cmd_t       head;

  assign in_stall = full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .fun_code     (fun_code),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .push         (push),
    .cmd          (push_cmd)
  );

  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tx_byte     (tx_byte),
    .frame_end   (frame_end),
    .error       (error),
    .last        (last)
  );

endmodule

// File: rtl/cpf_front.sv
module cpf_front
  import cpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        op,
  input  logic [7:0]  fun_code,
  input  logic [15:0] frame_length,
  input  logic [7:0]  data_byte,
  output logic        push,
  output cmd_t        cmd
);

  logic        frame_open;
  logic [15:0] bytes_left;

  assign push = in_valid && !in_stall;

  // Classify the incoming item against the frame state
  always_comb begin
    cmd.fun_code     = fun_code;
    cmd.frame_length = frame_length;
    cmd.data_byte    = data_byte;
    if (op == OP_START) begin
      cmd.kind  = KIND_START;
      cmd.close = (frame_length == 16'd0);
    end else if (!frame_open) begin
      cmd.kind  = KIND_ERROR;
      cmd.close = 1'b0;
    end else begin
      cmd.kind  = KIND_DATA;
      cmd.close = (bytes_left == 16'd1);
    end
  end

  // Track the open frame and the payload bytes still due
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 16'd0;
    end else if (push) begin
      case (cmd.kind)
        KIND_START: begin
          bytes_left <= frame_length;
          frame_open <= !cmd.close;
        end
        KIND_DATA: begin
          bytes_left <= bytes_left - 16'd1;
          if (cmd.close) begin
            frame_open <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/cpf_queue.sv
module cpf_queue
  import cpf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Write the slot at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/cpf_back.sv
module cpf_back
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       frame_end,
  output logic       error,
  output logic       last
);

  logic [2:0]  step;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic        adv;
  logic        fire;
  logic [7:0]  byte_sel;
  logic        is_path;
  logic        is_crc_lo;
  logic        is_err;
  logic        done;

  assign adv  = !out_valid || !out_stall;
  assign fire = head_valid && adv;
  assign pop  = fire && done;

  // Select the byte for the current step of the head command
  always_comb begin
    crc_in    = ((head.kind == KIND_START) && (step == 3'd0)) ? CRC_INIT : crc;
    byte_sel  = 8'h00;
    is_path   = 1'b0;
    is_crc_lo = 1'b0;
    is_err    = 1'b0;
    done      = 1'b1;
    case (head.kind)
      KIND_START: begin
        done = head.close ? (step == 3'd6) : (step == 3'd4);
        case (step)
          3'd0: begin byte_sel = sync_first;              is_path = 1'b1; end
          3'd1: begin byte_sel = sync_second;             is_path = 1'b1; end
          3'd2: begin byte_sel = head.fun_code;           is_path = 1'b1; end
          3'd3: begin byte_sel = head.frame_length[15:8]; is_path = 1'b1; end
          3'd4: begin byte_sel = head.frame_length[7:0];  is_path = 1'b1; end
          3'd5: byte_sel = crc_in[15:8];
          default: begin
            byte_sel  = crc_in[7:0];
            is_crc_lo = 1'b1;
          end
        endcase
      end
      KIND_DATA: begin
        done = head.close ? (step == 3'd2) : (step == 3'd0);
        case (step)
          3'd0: begin byte_sel = head.data_byte; is_path = 1'b1; end
          3'd1: byte_sel = crc_in[15:8];
          default: begin
            byte_sel  = crc_in[7:0];
            is_crc_lo = 1'b1;
          end
        endcase
      end
      default: begin
        is_err = 1'b1;
      end
    endcase
  end

  // Hold the output register, advance the step and fold path bytes into the CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
      crc       <= CRC_INIT;
    end else if (adv) begin
      out_valid <= head_valid;
      if (fire) begin
        step <= done ? 3'd0 : step + 3'd1;
        if (is_path) begin
          crc <= crc_byte(crc_in, byte_sel);
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      tx_byte   <= byte_sel;
      frame_end <= is_crc_lo;
      error     <= is_err;
      last      <= done;
    end
  end

endmodule

// File: tb/crc16_packet_framer_top_test.sv
`timescale 1ns / 1ps

module crc16_packet_framer_top_test;
  import cpf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 450;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       error;
    logic       last;
  } tx_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  fun_code;
  logic [15:0] frame_length;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic        error;
  logic        last;

  // Framer state as the testbench sees it
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  logic [15:0] frame_crc;
  logic [15:0] payload_left;
  logic        frame_active;

  tx_result_t  tx_expect[$];
  tx_result_t  item_bytes[$];
  int          failures = 0;
  int          items_sent;
  int          cycle_count = 0;
  logic        no_idle;

  crc16_packet_framer_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .fun_code     (fun_code),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_byte      (tx_byte),
    .frame_end    (frame_end),
    .error        (error),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[crc16_packet_framer_top] ERROR");
      $finish;
    end
  end

  // Bit-serial form of the reflected CRC-16 update
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Queue one framed byte and fold it into the running CRC
  task automatic add_framed(input logic [7:0] b);
    item_bytes.push_back('{b, 1'b0, 1'b0, 1'b0});
    frame_crc = crc16_update(frame_crc, b);
  endtask

  // Append the CRC trailer, high byte first, and close the frame
  task automatic add_trailer();
    item_bytes.push_back('{frame_crc[15:8], 1'b0, 1'b0, 1'b0});
    item_bytes.push_back('{frame_crc[7:0], 1'b1, 1'b0, 1'b0});
    frame_active = 1'b0;
  endtask

  // Work out the bytes one accepted transfer produces
  task automatic predict_frame_bytes(input logic op_i, input logic [7:0] fc,
                                     input logic [15:0] len, input logic [7:0] db);
    tx_result_t r;
    int         i;
    item_bytes.delete();
    if (op_i == OP_START) begin
      frame_crc = CRC_INIT;
      add_framed(sync_a);
      add_framed(sync_b);
      add_framed(fc);
      add_framed(len[15:8]);
      add_framed(len[7:0]);
      payload_left = len;
      frame_active = 1'b1;
      if (len == 16'd0) add_trailer();
    end else if (!frame_active) begin
      item_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
    end else begin
      add_framed(db);
      payload_left = payload_left - 16'd1;
      if (payload_left == 16'd0) add_trailer();
    end
    for (i = 0; i < item_bytes.size(); i++) begin
      r = item_bytes[i];
      r.last = (i == item_bytes.size() - 1);
      tx_expect.push_back(r);
    end
  endtask

  // Drive one item after a random gap and hold it until the transfer
  task automatic send_item(input logic op_i, input logic [7:0] fc,
                           input logic [15:0] len, input logic [7:0] db);
    int gap;
    gap = idle_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= op_i;
    fun_code     <= fc;
    frame_length <= len;
    data_byte    <= db;
    do @(posedge clk); while (in_stall);
    predict_frame_bytes(op_i, fc, len, db);
    items_sent++;
  endtask

  task automatic send_start(input logic [7:0] fc, input logic [15:0] len);
    send_item(OP_START, fc, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_data(input logic [7:0] db);
    send_item(OP_DATA, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), db);
  endtask

  // Drop valid and wait for every expected byte plus a settle margin
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tx_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SYNC_FIRST) sync_a = value;
    else sync_b = value;
  endtask

  task automatic set_syncs(input logic [7:0] first_b, input logic [7:0] second_b);
    wait_drained();
    write_sync(CFG_SYNC_FIRST, first_b);
    write_sync(CFG_SYNC_SECOND, second_b);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin
    tx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tx_expect.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %0h %0b %0b %0b",
                 $time, tx_byte, frame_end, error, last);
        failures++;
      end else begin
        want = tx_expect.pop_front();
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
        check_field("error", 8'(want.error), 8'(error));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // Stall the output side for a random gap before each transfer
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = idle_cycles();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Header with reset sync bytes, empty payload and one-byte payload
  task automatic test_default_header();
    send_start(8'h00, 16'd0);
    send_start(8'hFF, 16'd1);
    send_data(8'hFF);
  endtask

  // Data with no open frame gives a single error transfer
  task automatic test_orphan_data();
    send_data(8'h00);
    send_data(8'hA5);
  endtask

  // A new start abandons the open frame without a trailer
  task automatic test_abandoned_frame();
    send_start(8'h3C, 16'd3);
    send_data(8'h81);
    send_start(8'hC3, 16'd2);
    send_data(8'h00);
    send_data(8'h5A);
    send_data(8'h7E);
  endtask

  // Length byte extremes, all but the last frame cut short by the next start
  task automatic test_length_extremes();
    send_start(8'h96, 16'hFFFF);
    send_data(8'hFF);
    send_data(8'h00);
    send_start(8'h69, 16'h0100);
    send_start(8'h01, 16'h00FF);
    send_start(8'h80, 16'd1);
    send_data(8'h42);
  endtask

  // Sync bytes at both extremes
  task automatic test_sync_registers();
    set_syncs(8'h00, 8'hFF);
    send_start(8'h12, 16'd0);
    set_syncs(8'hFF, 8'h00);
    send_start(8'h34, 16'd1);
    send_data(8'hC0);
  endtask

  // Mostly complete frames with random content, some cut short, some noise
  task automatic test_random_traffic();
    int first_item;
    int phase;
    int pick;
    int len;
    int cut;
    int i;
    first_item = items_sent;
    phase = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ((items_sent - first_item) >= phase * 70) begin
        set_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        no_idle = (phase % 3 == 2);
        phase++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_start(8'($urandom_range(0, 255)), 16'(len));
        for (i = 0; i < len; i++) send_data(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        len = $urandom_range(1, 65535);
        cut = $urandom_range(0, 3);
        send_start(8'($urandom_range(0, 255)), 16'(len));
        for (i = 0; i < cut && i < len - 1; i++) send_data(8'($urandom_range(0, 255)));
      end else begin
        cut = $urandom_range(1, 3);
        for (i = 0; i < cut; i++) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SYNC_FIRST;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    op           = OP_START;
    fun_code     = 8'h00;
    frame_length = 16'h0000;
    data_byte    = 8'h00;
    sync_a       = SYNC_FIRST_RESET;
    sync_b       = SYNC_SECOND_RESET;
    frame_crc    = CRC_INIT;
    payload_left = 16'd0;
    frame_active = 1'b0;
    items_sent   = 0;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_header();
    test_orphan_data();
    test_abandoned_frame();
    test_length_extremes();
    test_sync_registers();
    test_random_traffic();

    wait_drained();
    if (failures == 0 && tx_expect.size() == 0) begin
      $display("[crc16_packet_framer_top] OK");
    end else begin
      $display("[crc16_packet_framer_top] ERROR");
    end
    $finish;
  end

endmodule
